// ===== rtl/tcb_pkg.sv =====
`default_nettype none
// ============================================================================
// tcb_pkg: shared types and constants of the text cursor bounds tracker
// Holds the beat formats, the configuration block, the register indexes and
// the coordinate width that all modules of the tracker agree on.
// ============================================================================
package tcb_pkg;

    // Internal coordinate width; coordinates wrap as two's complement.
    localparam int COORD_BITS = 16;
    // Wide enough for a coordinate plus a signed 16-bit step without overflow.
    localparam int WIDE_BITS  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;

    // Classic cell size before scaling.
    localparam logic [3:0] CELL_W = 4'd6;
    localparam logic [3:0] CELL_H = 4'd8;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_NUL = 8'd0;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        CFG_CUSTOM_FONT    = 3'd0,
        CFG_TEXT_SCALE     = 3'd1,
        CFG_WRAP_ENABLE    = 3'd2,
        CFG_DISPLAY_WIDTH  = 3'd3,
        CFG_DISPLAY_HEIGHT = 3'd4,
        CFG_FIRST_CODE     = 3'd5,
        CFG_LAST_CODE      = 3'd6,
        CFG_LINE_ADVANCE   = 3'd7
    } cfg_index_t;

    localparam int CFG_DATA_BITS = 15;

    // Register values after reset.
    localparam logic        RST_CUSTOM_FONT    = 1'b0;
    localparam logic [4:0]  RST_TEXT_SCALE     = 5'd1;
    localparam logic        RST_WRAP_ENABLE    = 1'b1;
    localparam logic [14:0] RST_DISPLAY_WIDTH  = 15'd240;
    localparam logic [14:0] RST_DISPLAY_HEIGHT = 15'd240;
    localparam logic [7:0]  RST_FIRST_CODE     = 8'd32;
    localparam logic [7:0]  RST_LAST_CODE      = 8'd126;
    localparam logic [7:0]  RST_LINE_ADVANCE   = 8'd8;

    typedef struct packed {
        logic        custom_font;
        logic [4:0]  text_scale;
        logic        wrap_enable;
        logic [14:0] display_width;
        logic [14:0] display_height;
        logic [7:0]  first_code;
        logic [7:0]  last_code;
        logic [7:0]  line_advance;
    } cfg_t;

    // What a character does to the layout.
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_GLYPH   = 2'd2
    } kind_t;

    typedef struct packed {
        logic               start_req;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         char_code;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic [7:0]         glyph_advance;
        logic signed [7:0]  glyph_x_offset;
        logic signed [7:0]  glyph_y_offset;
    } item_beat_t;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [15:0]        box_w;
        logic [15:0]        box_h;
        logic signed [15:0] cursor_x_out;
        logic signed [15:0] cursor_y_out;
    } res_beat_t;

    // Decoded and scaled character, held between the two stages.
    typedef struct packed {
        logic               start;
        coord_t             start_x;
        coord_t             start_y;
        kind_t              kind;
        logic [12:0]        line_h;
        logic signed [15:0] wrap_w;
        logic signed [13:0] off_x;
        logic signed [13:0] off_y;
        logic [12:0]        ext_w;
        logic [12:0]        ext_h;
        logic [12:0]        adv;
    } prep_beat_t;

endpackage
`default_nettype wire

// ===== rtl/text_cursor_bounds_tracker.sv =====
`default_nettype none
// ============================================================================
// text_cursor_bounds_tracker: text layout cursor and bounding box tracker
// Lays out a character stream and reports the running bounding box and the
// cursor after every character.
// ============================================================================
// Usage:
//   Input channel (item_valid / item_stall / item) carries one character beat,
//   with start_req to load a new origin and clear the extents. The result
//   channel (res_valid / res_stall / res) returns one beat per character with
//   the box (x, y, w, h) and the cursor after that character.
//   A beat accepted into the input register is applied by the layout stage,
//   which loads its result into the result register. Throughput is one
//   character per cycle unless res_stall holds the result; the layout stage
//   updates the cursor and extent registers together, which sets this rate.
//   The input register and the result register decouple the channels: while
//   a result waits under res_stall the next character is still taken into the
//   input register, and only then does item_stall rise.
//   Configuration is written through cfg_write / cfg_index / cfg_data by the
//   user, only while no character is in flight; the block does not enforce it.
//   Reset (rst_n low, asynchronous) returns the registers to their defaults,
//   puts the cursor and origin at zero and empties the extents. Both channels
//   come out of reset with no beat held.
// ============================================================================
module text_cursor_bounds_tracker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [tcb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire tcb_pkg::item_beat_t                item,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output tcb_pkg::res_beat_t                      res
);

    tcb_pkg::cfg_t        cfg;
    logic                 prep_valid;
    tcb_pkg::prep_beat_t  prep_beat;
    logic                 take;

    // Configuration registers.
    tcb_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input stage: character class and scaled glyph metrics.
    tcb_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .prep_valid (prep_valid),
        .prep_beat  (prep_beat),
        .take       (take)
    );

    // Layout stage: cursor, extents and the result register.
    tcb_layout u_layout
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prep_valid (prep_valid),
        .prep_beat  (prep_beat),
        .take       (take),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule
`default_nettype wire

// ===== rtl/tcb_cfg_regs.sv =====
`default_nettype none
// ============================================================================
// tcb_cfg_regs: configuration register file
// Plain write port; each register keeps the low bits of the write data.
// ============================================================================
module tcb_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [tcb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output tcb_pkg::cfg_t                           cfg
);

    tcb_pkg::cfg_t cfg_reg;
    tcb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (tcb_pkg::cfg_index_t'(cfg_index))
                tcb_pkg::CFG_CUSTOM_FONT:    cfg_next.custom_font    = cfg_data[0];
                tcb_pkg::CFG_TEXT_SCALE:     cfg_next.text_scale     = cfg_data[4:0];
                tcb_pkg::CFG_WRAP_ENABLE:    cfg_next.wrap_enable    = cfg_data[0];
                tcb_pkg::CFG_DISPLAY_WIDTH:  cfg_next.display_width  = cfg_data[14:0];
                tcb_pkg::CFG_DISPLAY_HEIGHT: cfg_next.display_height = cfg_data[14:0];
                tcb_pkg::CFG_FIRST_CODE:     cfg_next.first_code     = cfg_data[7:0];
                tcb_pkg::CFG_LAST_CODE:      cfg_next.last_code      = cfg_data[7:0];
                tcb_pkg::CFG_LINE_ADVANCE:   cfg_next.line_advance   = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.custom_font    <= tcb_pkg::RST_CUSTOM_FONT;
            cfg_reg.text_scale     <= tcb_pkg::RST_TEXT_SCALE;
            cfg_reg.wrap_enable    <= tcb_pkg::RST_WRAP_ENABLE;
            cfg_reg.display_width  <= tcb_pkg::RST_DISPLAY_WIDTH;
            cfg_reg.display_height <= tcb_pkg::RST_DISPLAY_HEIGHT;
            cfg_reg.first_code     <= tcb_pkg::RST_FIRST_CODE;
            cfg_reg.last_code      <= tcb_pkg::RST_LAST_CODE;
            cfg_reg.line_advance   <= tcb_pkg::RST_LINE_ADVANCE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/tcb_prep.sv =====
`default_nettype none
// ============================================================================
// tcb_prep: input stage
// Classifies the character and scales the glyph metrics, then holds the
// result in the input register until the layout stage takes it.
// ============================================================================
module tcb_prep
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcb_pkg::cfg_t       cfg,
    input  wire logic                item_valid,
    input  wire tcb_pkg::item_beat_t item,
    output logic                     item_stall,
    output logic                     prep_valid,
    output tcb_pkg::prep_beat_t      prep_beat,
    input  wire logic                take
);

    logic                 prep_valid_reg;
    logic                 prep_valid_next;
    tcb_pkg::prep_beat_t  prep_beat_reg;
    tcb_pkg::prep_beat_t  prep_beat_next;

    logic                 load;
    logic signed [5:0]    scale_s;
    logic [7:0]           cell_w_s;
    logic [7:0]           cell_h_s;
    logic signed [9:0]    span_x;
    logic signed [15:0]   span_x_s;
    tcb_pkg::kind_t       kind;

    assign item_stall = prep_valid_reg && !take;
    assign load       = item_valid && !item_stall;

    assign scale_s  = $signed({1'b0, cfg.text_scale});
    assign cell_w_s = 8'(cfg.text_scale) * 8'(tcb_pkg::CELL_W);
    assign cell_h_s = 8'(cfg.text_scale) * 8'(tcb_pkg::CELL_H);
    // Right edge of the glyph relative to the cursor, for the wrap test.
    assign span_x   = 10'(item.glyph_x_offset) + 10'($signed({1'b0, item.glyph_width}));
    assign span_x_s = 16'(span_x) * 16'(scale_s);

    always_comb
    begin
        if (item.char_code inside {tcb_pkg::CHAR_NUL, tcb_pkg::CHAR_CR})
        begin
            kind = tcb_pkg::KIND_NONE;
        end
        else if (item.char_code == tcb_pkg::CHAR_LF)
        begin
            kind = tcb_pkg::KIND_NEWLINE;
        end
        else if (!cfg.custom_font)
        begin
            kind = tcb_pkg::KIND_GLYPH;
        end
        else if (item.char_code >= cfg.first_code && item.char_code <= cfg.last_code)
        begin
            kind = tcb_pkg::KIND_GLYPH;
        end
        else
        begin
            kind = tcb_pkg::KIND_NONE;
        end
    end

    always_comb
    begin
        prep_beat_next.start   = item.start_req;
        prep_beat_next.start_x = tcb_pkg::coord_t'(item.start_x);
        prep_beat_next.start_y = tcb_pkg::coord_t'(item.start_y);
        prep_beat_next.kind    = kind;
        if (cfg.custom_font)
        begin
            prep_beat_next.line_h = 13'(cfg.line_advance) * 13'(cfg.text_scale);
            prep_beat_next.wrap_w = span_x_s;
            prep_beat_next.off_x  = 14'(item.glyph_x_offset) * 14'(scale_s);
            prep_beat_next.off_y  = 14'(item.glyph_y_offset) * 14'(scale_s);
            prep_beat_next.ext_w  = 13'(item.glyph_width) * 13'(cfg.text_scale);
            prep_beat_next.ext_h  = 13'(item.glyph_height) * 13'(cfg.text_scale);
            prep_beat_next.adv    = 13'(item.glyph_advance) * 13'(cfg.text_scale);
        end
        else
        begin
            prep_beat_next.line_h = 13'(cell_h_s);
            prep_beat_next.wrap_w = $signed(16'(cell_w_s));
            prep_beat_next.off_x  = '0;
            prep_beat_next.off_y  = '0;
            prep_beat_next.ext_w  = 13'(cell_w_s);
            prep_beat_next.ext_h  = 13'(cell_h_s);
            prep_beat_next.adv    = 13'(cell_w_s);
        end
    end

    always_comb
    begin
        prep_valid_next = prep_valid_reg;
        if (!item_stall)
        begin
            prep_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= prep_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prep_beat_reg <= prep_beat_next;
        end
    end

    assign prep_valid = prep_valid_reg;
    assign prep_beat  = prep_beat_reg;

endmodule
`default_nettype wire

// ===== rtl/tcb_layout.sv =====
`default_nettype none
// ============================================================================
// tcb_layout: layout stage
// Owns cursor, origin and extent registers, applies one character per unstalled
// cycle and loads the bounding box and cursor into the result register.
// ============================================================================
module tcb_layout
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcb_pkg::cfg_t       cfg,
    input  wire logic                prep_valid,
    input  wire tcb_pkg::prep_beat_t prep_beat,
    output logic                     take,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output tcb_pkg::res_beat_t       res
);

    tcb_pkg::coord_t    cursor_x_reg, cursor_x_next;
    tcb_pkg::coord_t    cursor_y_reg, cursor_y_next;
    tcb_pkg::coord_t    origin_x_reg, origin_x_next;
    tcb_pkg::coord_t    origin_y_reg, origin_y_next;
    tcb_pkg::coord_t    min_x_reg, min_x_next;
    tcb_pkg::coord_t    min_y_reg, min_y_next;
    tcb_pkg::coord_t    max_x_reg, max_x_next;
    tcb_pkg::coord_t    max_y_reg, max_y_next;
    logic               res_valid_reg, res_valid_next;
    tcb_pkg::res_beat_t res_reg, res_next;

    tcb_pkg::coord_t    cx, cy, minx, miny, maxx, maxy;
    tcb_pkg::coord_t    cy_lf, cx_g, cy_g, x1, y1, x2, y2;
    tcb_pkg::wide_t     right_edge;
    tcb_pkg::wide_t     span_w, span_h;
    logic               wrap;

    assign take = prep_valid && (!res_valid_reg || !res_stall);

    always_comb
    begin
        // A start beat reloads the origin and empties the extents first.
        if (prep_beat.start)
        begin
            cx   = prep_beat.start_x;
            cy   = prep_beat.start_y;
            minx = tcb_pkg::coord_t'(cfg.display_width);
            miny = tcb_pkg::coord_t'(cfg.display_height);
            maxx = '1;
            maxy = '1;
            origin_x_next = prep_beat.start_x;
            origin_y_next = prep_beat.start_y;
        end
        else
        begin
            cx   = cursor_x_reg;
            cy   = cursor_y_reg;
            minx = min_x_reg;
            miny = min_y_reg;
            maxx = max_x_reg;
            maxy = max_y_reg;
            origin_x_next = origin_x_reg;
            origin_y_next = origin_y_reg;
        end

        cy_lf      = cy + tcb_pkg::coord_t'(prep_beat.line_h);
        // The wrap test is made at full precision, not on wrapped coordinates.
        right_edge = tcb_pkg::wide_t'(cx) + tcb_pkg::wide_t'(prep_beat.wrap_w);
        wrap       = cfg.wrap_enable &&
                     (right_edge > tcb_pkg::wide_t'(cfg.display_width));
        cx_g = wrap ? '0 : cx;
        cy_g = wrap ? cy_lf : cy;
        x1   = cx_g + tcb_pkg::coord_t'(prep_beat.off_x);
        y1   = cy_g + tcb_pkg::coord_t'(prep_beat.off_y);
        x2   = x1 + tcb_pkg::coord_t'(prep_beat.ext_w) - tcb_pkg::coord_t'(1);
        y2   = y1 + tcb_pkg::coord_t'(prep_beat.ext_h) - tcb_pkg::coord_t'(1);

        cursor_x_next = cx;
        cursor_y_next = cy;
        min_x_next    = minx;
        min_y_next    = miny;
        max_x_next    = maxx;
        max_y_next    = maxy;
        case (prep_beat.kind)
            tcb_pkg::KIND_NONE:
            begin
                cursor_x_next = cx;
            end
            tcb_pkg::KIND_NEWLINE:
            begin
                cursor_x_next = '0;
                cursor_y_next = cy_lf;
            end
            tcb_pkg::KIND_GLYPH:
            begin
                cursor_x_next = cx_g + tcb_pkg::coord_t'(prep_beat.adv);
                cursor_y_next = cy_g;
                min_x_next    = (x1 < minx) ? x1 : minx;
                min_y_next    = (y1 < miny) ? y1 : miny;
                max_x_next    = (x2 > maxx) ? x2 : maxx;
                max_y_next    = (y2 > maxy) ? y2 : maxy;
            end
            default:
            begin
                cursor_x_next = cx;
            end
        endcase

        span_w = tcb_pkg::wide_t'(max_x_next) - tcb_pkg::wide_t'(min_x_next)
                 + tcb_pkg::wide_t'(1);
        span_h = tcb_pkg::wide_t'(max_y_next) - tcb_pkg::wide_t'(min_y_next)
                 + tcb_pkg::wide_t'(1);

        if (max_x_next >= min_x_next)
        begin
            res_next.box_x = 16'(min_x_next);
            res_next.box_w = 16'(span_w);
        end
        else
        begin
            res_next.box_x = 16'(origin_x_next);
            res_next.box_w = '0;
        end
        if (max_y_next >= min_y_next)
        begin
            res_next.box_y = 16'(min_y_next);
            res_next.box_h = 16'(span_h);
        end
        else
        begin
            res_next.box_y = 16'(origin_y_next);
            res_next.box_h = '0;
        end
        res_next.cursor_x_out = 16'(cursor_x_next);
        res_next.cursor_y_out = 16'(cursor_y_next);
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            min_x_reg     <= tcb_pkg::coord_t'(tcb_pkg::RST_DISPLAY_WIDTH);
            min_y_reg     <= tcb_pkg::coord_t'(tcb_pkg::RST_DISPLAY_HEIGHT);
            max_x_reg     <= '1;
            max_y_reg     <= '1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
                origin_x_reg <= origin_x_next;
                origin_y_reg <= origin_y_next;
                min_x_reg    <= min_x_next;
                min_y_reg    <= min_y_next;
                max_x_reg    <= max_x_next;
                max_y_reg    <= max_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // A held character is only ever blocked by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid && !take |-> res_valid && res_stall)
        else $error("layout stage blocked without a stalled result");

    // A new result appears only after a character was applied.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(take))
        else $error("result valid rose without a character");

    // A newline always returns the cursor to column zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && prep_beat.kind == tcb_pkg::KIND_NEWLINE |=> res.cursor_x_out == '0)
        else $error("newline left cursor x nonzero");

    // A start beat that places nothing reports the new origin as the cursor.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && prep_beat.start && prep_beat.kind == tcb_pkg::KIND_NONE
        |=> res.cursor_x_out == 16'($past(prep_beat.start_x)))
        else $error("start beat did not load the cursor");
`endif

endmodule
`default_nettype wire

// ===== tb/tcb_layout_checker.sv =====
`default_nettype none
// ============================================================================
// tcb_layout_checker: scoreboard for the text cursor bounds tracker
// Mirrors the configuration writes, predicts the box and cursor for every
// accepted character beat and compares each result beat field by field.
// ============================================================================
module tcb_layout_checker
    import tcb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     item_valid,
    input  wire logic                     item_stall,
    input  wire item_beat_t               item,
    input  wire logic                     res_valid,
    input  wire logic                     res_stall,
    input  wire res_beat_t                res,
    output int                            mismatches,
    output int                            pending,
    output int                            checked
);

    cfg_t      regs;
    coord_t    cur_x, cur_y, org_x, org_y;
    coord_t    lo_x, lo_y, hi_x, hi_y;
    res_beat_t boxes_due[$];

    function automatic void empty_extents();
        lo_x = coord_t'(longint'(regs.display_width));
        lo_y = coord_t'(longint'(regs.display_height));
        hi_x = coord_t'(-1);
        hi_y = coord_t'(-1);
    endfunction

    // Corners are wrapped to the coordinate width before they are compared.
    function automatic void grow_extents(longint x1, longint y1, longint x2, longint y2);
        coord_t a, b, c, d;
        a = coord_t'(x1);
        b = coord_t'(y1);
        c = coord_t'(x2);
        d = coord_t'(y2);
        if (a < lo_x) lo_x = a;
        if (b < lo_y) lo_y = b;
        if (c > hi_x) hi_x = c;
        if (d > hi_y) hi_y = d;
    endfunction

    function automatic res_beat_t lay_out(item_beat_t it);
        longint    s, dw, lh, cw, ch, cx, cy, gw, gh, adv, xo, yo, x1, y1;
        res_beat_t r;
        s  = longint'(regs.text_scale);
        dw = longint'(regs.display_width);
        cw = longint'(CELL_W) * s;
        ch = longint'(CELL_H) * s;
        if (regs.custom_font)
            lh = longint'(regs.line_advance) * s;
        else
            lh = ch;
        if (it.start_req)
        begin
            org_x = it.start_x;
            org_y = it.start_y;
            cur_x = org_x;
            cur_y = org_y;
            empty_extents();
        end
        cx = cur_x;
        cy = cur_y;
        if (it.char_code == CHAR_NUL || it.char_code == CHAR_CR)
        begin
        end
        else if (it.char_code == CHAR_LF)
        begin
            cx = 0;
            cy = cy + lh;
        end
        else if (!regs.custom_font)
        begin
            // The wrap test is done at full precision, not at the coordinate width.
            if (regs.wrap_enable && cx + cw > dw)
            begin
                cx = 0;
                cy = longint'(coord_t'(cy + lh));
            end
            grow_extents(cx, cy, cx + cw - 1, cy + ch - 1);
            cx = cx + cw;
        end
        else if (it.char_code >= regs.first_code && it.char_code <= regs.last_code)
        begin
            gw  = longint'(it.glyph_width);
            gh  = longint'(it.glyph_height);
            adv = longint'(it.glyph_advance);
            xo  = longint'($signed(it.glyph_x_offset));
            yo  = longint'($signed(it.glyph_y_offset));
            if (regs.wrap_enable && cx + (xo + gw) * s > dw)
            begin
                cx = 0;
                cy = longint'(coord_t'(cy + lh));
            end
            x1 = longint'(coord_t'(cx + xo * s));
            y1 = longint'(coord_t'(cy + yo * s));
            grow_extents(x1, y1, x1 + gw * s - 1, y1 + gh * s - 1);
            cx = cx + adv * s;
        end
        cur_x = coord_t'(cx);
        cur_y = coord_t'(cy);

        if (hi_x >= lo_x)
        begin
            r.box_x = lo_x;
            r.box_w = 16'(longint'(hi_x) - longint'(lo_x) + 1);
        end
        else
        begin
            r.box_x = org_x;
            r.box_w = '0;
        end
        if (hi_y >= lo_y)
        begin
            r.box_y = lo_y;
            r.box_h = 16'(longint'(hi_y) - longint'(lo_y) + 1);
        end
        else
        begin
            r.box_y = org_y;
            r.box_h = '0;
        end
        r.cursor_x_out = cur_x;
        r.cursor_y_out = cur_y;
        return r;
    endfunction

    function automatic int field_off(string name, logic [15:0] want, logic [15:0] got,
                                     bit sgn);
        if (got === want)
            return 0;
        if (sgn)
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        else
            $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_beat_t want;
        if (!rst_n)
        begin
            regs.custom_font    = RST_CUSTOM_FONT;
            regs.text_scale     = RST_TEXT_SCALE;
            regs.wrap_enable    = RST_WRAP_ENABLE;
            regs.display_width  = RST_DISPLAY_WIDTH;
            regs.display_height = RST_DISPLAY_HEIGHT;
            regs.first_code     = RST_FIRST_CODE;
            regs.last_code      = RST_LAST_CODE;
            regs.line_advance   = RST_LINE_ADVANCE;
            cur_x = '0;
            cur_y = '0;
            org_x = '0;
            org_y = '0;
            empty_extents();
            boxes_due.delete();
            mismatches = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // Results leave before new characters enter, so the oldest is popped first.
            if (res_valid && !res_stall)
            begin
                if (boxes_due.size() == 0)
                begin
                    $error("result beat arrived with no character outstanding");
                    mismatches++;
                end
                else
                begin
                    want = boxes_due.pop_front();
                    mismatches += field_off("box_x", want.box_x, res.box_x, 1'b1)
                                + field_off("box_y", want.box_y, res.box_y, 1'b1)
                                + field_off("box_w", want.box_w, res.box_w, 1'b0)
                                + field_off("box_h", want.box_h, res.box_h, 1'b0)
                                + field_off("cursor_x_out", want.cursor_x_out,
                                            res.cursor_x_out, 1'b1)
                                + field_off("cursor_y_out", want.cursor_y_out,
                                            res.cursor_y_out, 1'b1);
                    checked++;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CUSTOM_FONT:    regs.custom_font    = cfg_data[0];
                    CFG_TEXT_SCALE:     regs.text_scale     = cfg_data[4:0];
                    CFG_WRAP_ENABLE:    regs.wrap_enable    = cfg_data[0];
                    CFG_DISPLAY_WIDTH:  regs.display_width  = cfg_data[14:0];
                    CFG_DISPLAY_HEIGHT: regs.display_height = cfg_data[14:0];
                    CFG_FIRST_CODE:     regs.first_code     = cfg_data[7:0];
                    CFG_LAST_CODE:      regs.last_code      = cfg_data[7:0];
                    CFG_LINE_ADVANCE:   regs.line_advance   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                boxes_due.push_back(lay_out(item));
            pending = boxes_due.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/text_cursor_bounds_tracker_tb.sv =====
`default_nettype none
// ============================================================================
// text_cursor_bounds_tracker_tb: top of the tracker testbench
// Drives character beats and register writes into the tracker, stalls the
// result channel at random and leaves prediction and comparison to the
// checker beside the block. A directed part visits the special characters,
// coordinate extremes and corner settings; random strings follow under a
// series of random register settings.
// ============================================================================
module text_cursor_bounds_tracker_tb;
    import tcb_pkg::*;

    // The limit is several times the slowest correct run of about 1600 beats,
    // each slowed by a sender gap, a receiver stall and the pipeline latency.
    localparam int CYCLE_LIMIT  = 250000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_CHARS  = 130;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [2:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     item_valid;
    logic                     item_stall;
    item_beat_t               item;
    logic                     res_valid;
    logic                     res_stall;
    res_beat_t                res;

    int   mismatches;
    int   pending;
    int   checked;
    int   chars_sent    = 0;
    int   settings_used = 0;
    int   cycles        = 0;
    bit   tx_steady     = 0;
    bit   rx_steady     = 0;
    cfg_t now_cfg;

    text_cursor_bounds_tracker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    tcb_layout_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a lost or stuck beat shows up here rather than as a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d beats outstanding.",
                     cycles, pending);
            $display("FAIL text_cursor_bounds_tracker");
            $finish;
        end
    end

    // Result side. Before every beat it takes, the receiver holds stall high for
    // a random number of cycles. Now and then it switches into a steady mode with
    // no stalls at all, so back-to-back results are exercised too.
    initial
    begin : result_sink
        int hold;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_steady ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            if (hold != 0)
            begin
                res_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall = 1'b0;
            do @(posedge clk); while (res_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // One register write; the block takes it at the rising edge in between.
    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Register writes are only legal with nothing in flight, so every phase
    // change first drops valid and waits until the checker has seen every result.
    task automatic wait_idle();
        item_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        wait_idle();
        write_reg(CFG_CUSTOM_FONT,    c.custom_font);
        write_reg(CFG_TEXT_SCALE,     c.text_scale);
        write_reg(CFG_WRAP_ENABLE,    c.wrap_enable);
        write_reg(CFG_DISPLAY_WIDTH,  c.display_width);
        write_reg(CFG_DISPLAY_HEIGHT, c.display_height);
        write_reg(CFG_FIRST_CODE,     c.first_code);
        write_reg(CFG_LAST_CODE,      c.last_code);
        write_reg(CFG_LINE_ADVANCE,   c.line_advance);
        now_cfg = c;
        settings_used++;
    endtask

    function automatic cfg_t make_settings(int font, int scale, int wrap, int w, int h,
                                           int first, int last, int adv);
        cfg_t c;
        c.custom_font    = font[0];
        c.text_scale     = scale[4:0];
        c.wrap_enable    = wrap[0];
        c.display_width  = w[14:0];
        c.display_height = h[14:0];
        c.first_code     = first[7:0];
        c.last_code      = last[7:0];
        c.line_advance   = adv[7:0];
        return c;
    endfunction

    // Settings for a random phase. Each register lands on one of its extremes
    // often enough to matter; the rest are values typical of a small display.
    function automatic cfg_t random_settings();
        int scale, w, h, first, last, adv;
        case ($urandom_range(0, 5))
            0:       scale = 1;
            1:       scale = 16;
            default: scale = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 5))
            0:       w = 1;
            1:       w = 32767;
            2:       w = $urandom_range(1, 32767);
            default: w = $urandom_range(40, 400);
        endcase
        case ($urandom_range(0, 5))
            0:       h = 1;
            1:       h = 32767;
            2:       h = $urandom_range(1, 32767);
            default: h = $urandom_range(40, 400);
        endcase
        case ($urandom_range(0, 4))
            0:
            begin
                first = 0;
                last  = 255;
            end
            1:
            begin
                first = 32;
                last  = 126;
            end
            2:
            begin
                // Either order; an inverted range turns every code away.
                first = $urandom_range(0, 255);
                last  = $urandom_range(0, 255);
            end
            default:
            begin
                first = $urandom_range(0, 120);
                last  = first + $urandom_range(0, 135);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       adv = 0;
            1:       adv = 255;
            default: adv = $urandom_range(4, 24);
        endcase
        return make_settings($urandom_range(0, 1), scale, $urandom_range(0, 3) != 0,
                             w, h, first, last, adv);
    endfunction

    function automatic item_beat_t char_beat(bit st, int sx, int sy, logic [7:0] code,
                                             int gw, int gh, int adv, int xo, int yo);
        item_beat_t b;
        b.start_req      = st;
        b.start_x        = sx[15:0];
        b.start_y        = sy[15:0];
        b.char_code      = code;
        b.glyph_width    = gw[7:0];
        b.glyph_height   = gh[7:0];
        b.glyph_advance  = adv[7:0];
        b.glyph_x_offset = xo[7:0];
        b.glyph_y_offset = yo[7:0];
        return b;
    endfunction

    // A random character of a string. Most codes fall inside the font range of
    // the current setting so that custom glyphs really lay out; the rest are
    // the control codes and codes anywhere in the byte. Metrics stay small most
    // of the time so the box grows over many characters before it wraps.
    function automatic item_beat_t random_char(bit st);
        item_beat_t b;
        int         pick;
        b.start_req = st;
        if ($urandom_range(0, 3) == 0)
        begin
            b.start_x = $urandom;
            b.start_y = $urandom;
        end
        else
        begin
            b.start_x = $urandom_range(0, 320) - 20;
            b.start_y = $urandom_range(0, 320) - 20;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6)
            b.char_code = CHAR_NUL;
        else if (pick < 12)
            b.char_code = CHAR_LF;
        else if (pick < 16)
            b.char_code = CHAR_CR;
        else if (pick < 26 || now_cfg.first_code > now_cfg.last_code)
            b.char_code = $urandom_range(0, 255);
        else
            b.char_code = $urandom_range(now_cfg.first_code, now_cfg.last_code);
        if ($urandom_range(0, 4) == 0)
        begin
            b.glyph_width    = $urandom;
            b.glyph_height   = $urandom;
            b.glyph_advance  = $urandom;
            b.glyph_x_offset = $urandom;
            b.glyph_y_offset = $urandom;
        end
        else
        begin
            b.glyph_width    = $urandom_range(0, 12);
            b.glyph_height   = $urandom_range(0, 16);
            b.glyph_advance  = $urandom_range(0, 14);
            b.glyph_x_offset = $urandom_range(0, 8) - 4;
            b.glyph_y_offset = $urandom_range(0, 16) - 12;
        end
        return b;
    endfunction

    // Offer one beat and hold it until the block takes it. The gap in front of
    // the beat is drawn per beat, except in steady stretches where beats follow
    // back to back and valid stays high across the boundary.
    task automatic send_char(input item_beat_t b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 63) == 0)
            tx_steady = !tx_steady;
        if (gap != 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = b;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall !== 1'b0);
        @(negedge clk);
        chars_sent++;
    endtask

    initial
    begin : stimulus
        int  left;
        int  run;

        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_CUSTOM_FONT;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        now_cfg    = make_settings(RST_CUSTOM_FONT, RST_TEXT_SCALE, RST_WRAP_ENABLE,
                                   RST_DISPLAY_WIDTH, RST_DISPLAY_HEIGHT,
                                   RST_FIRST_CODE, RST_LAST_CODE, RST_LINE_ADVANCE);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, classic 6x8 cells. The first beat is a bare string
        // terminator, so the box must come back empty at the origin. Then a
        // glyph, carriage return, newline and the top code. A string placed so
        // that its cell just touches the right edge does not wrap, the next
        // one does. Origins at both ends of the coordinate range follow; the
        // high one wraps and pushes the cursor past the top of the range.
        send_char(char_beat(1'b1, 0, 0, CHAR_NUL, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd65, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, CHAR_CR, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, CHAR_LF, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd255, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b1, 234, 5, 8'd66, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd67, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b1, -32768, -32768, 8'd68, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b1, 32767, 32767, 8'd1, 0, 0, 0, 0, 0));

        // Custom glyphs at scale 16 on a display one pixel high. Codes
        // just outside the font range are skipped, a zero-sized glyph still
        // moves the extents, and the metrics go to their extremes.
        load_settings(make_settings(1, 16, 1, 32767, 1, 32, 126, 255));
        send_char(char_beat(1'b1, 10, 20, 8'd31, 5, 5, 5, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd127, 5, 5, 5, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd32, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd126, 255, 255, 255, -128, 127));
        send_char(char_beat(1'b0, 0, 0, 8'd65, 255, 1, 3, 127, -128));
        send_char(char_beat(1'b0, 0, 0, CHAR_LF, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b1, 32767, -32768, 8'd64, 8, 8, 8, 0, 0));

        // Scale zero with an inverted font range: no code counts as a glyph,
        // and a newline with a zero line height leaves the cursor row alone.
        load_settings(make_settings(1, 0, 0, 1, 32767, 200, 100, 0));
        send_char(char_beat(1'b1, 5, 5, 8'd150, 9, 9, 9, 1, 1));
        send_char(char_beat(1'b0, 0, 0, CHAR_LF, 0, 0, 0, 0, 0));

        // Classic cells at scale zero on a display one pixel wide: every cell is
        // empty and wraps whenever the cursor sits right of the edge.
        load_settings(make_settings(0, 0, 1, 1, 32767, 0, 255, 255));
        send_char(char_beat(1'b1, 5, 5, 8'd66, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, 8'd67, 0, 0, 0, 0, 0));
        send_char(char_beat(1'b0, 0, 0, CHAR_LF, 0, 0, 0, 0, 0));

        // The full byte as the font range, with wrap off.
        load_settings(make_settings(1, 1, 0, 240, 240, 0, 255, 8));
        send_char(char_beat(1'b1, 0, 0, 8'd255, 3, 4, 5, 1, 1));
        send_char(char_beat(1'b0, 0, 0, 8'd1, 3, 4, 5, -1, -1));

        // Random part: each phase picks new settings, then lays out strings of
        // random length, each opened by a start beat. A stray start in the middle
        // of a string breaks it off now and then.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            load_settings(random_settings());
            left = PHASE_CHARS;
            while (left > 0)
            begin
                send_char(random_char(1'b1));
                left--;
                run = $urandom_range(1, 30);
                while (run > 0 && left > 0)
                begin
                    send_char(random_char($urandom_range(0, 39) == 0));
                    run--;
                    left--;
                end
            end
        end

        // Drain, then keep the clock running so that any extra beat still shows.
        wait_idle();
        repeat (4) @(negedge clk);

        $display("Laid out %0d characters under %0d register settings;",
                 chars_sent, settings_used);
        $display("%0d result beats checked over classic and custom fonts, scales 0 to 16,",
                 checked);
        $display("wrap on and off, and NUL, CR, LF and out-of-range codes.");
        if (mismatches == 0)
            $display("PASS text_cursor_bounds_tracker");
        else
            $display("FAIL text_cursor_bounds_tracker");
        $finish;
    end

endmodule
`default_nettype wire
